// ----- src/vna_pkg.sv -----
// Shared types, constants and helper functions for the vertex normal accumulator.
// No dependencies; every other file except vna_ram imports this package.
`default_nettype none

package vna_pkg;

  localparam int COORD_W  = 16;
  localparam int INDEX_W  = 12;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int NORMAL_W = 48;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FACE  = 2'd1,
    OP_READ  = 2'd2
  } vna_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_MUL,
    ST_CROSS,
    ST_ACC_A,
    ST_ACC_B,
    ST_ACC_C,
    ST_RD_N,
    ST_RESP
  } vna_state_t;

  typedef struct packed {
    logic [1:0]                op;
    logic [INDEX_W-1:0]        vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [INDEX_W-1:0]        corner_a;
    logic [INDEX_W-1:0]        corner_b;
    logic [INDEX_W-1:0]        corner_c;
  } vna_in_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
  } vna_out_t;

  // one stored position
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vna_vec_t;

  // one stored normal
  typedef struct packed {
    logic signed [NORMAL_W-1:0] x;
    logic signed [NORMAL_W-1:0] y;
    logic signed [NORMAL_W-1:0] z;
  } vna_norm_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } vna_cross_t;

  // controls for the cross product datapath
  typedef struct packed {
    logic load_pa;
    logic load_pb;
    logic mul_en;
    logic cross_en;
  } vna_xctl_t;

  // controls for the normal update
  typedef struct packed {
    logic we;
    logic fwd;
  } vna_actl_t;

  function automatic logic signed [NORMAL_W-1:0] sat_sub(
    input logic signed [NORMAL_W-1:0] acc,
    input logic signed [CROSS_W-1:0]  d
  );
    logic signed [NORMAL_W:0]   diff;
    logic signed [NORMAL_W-1:0] res;
    diff = (NORMAL_W+1)'(acc) - (NORMAL_W+1)'(d);
    if (diff[NORMAL_W] != diff[NORMAL_W-1]) begin
      res = diff[NORMAL_W] ? {1'b1, {(NORMAL_W-1){1'b0}}} : {1'b0, {(NORMAL_W-1){1'b1}}};
    end else begin
      res = diff[NORMAL_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/vna_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read (old data
// on a same-address collision). No dependencies.
`default_nettype none

module vna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/vna_cross.sv -----
// Edge and cross product datapath: latches corner positions, multiplies, forms u x v.
// Depends on vna_pkg.
`default_nettype none

module vna_cross
  import vna_pkg::*;
(
  input  wire logic       clk,
  input  wire vna_xctl_t  ctl,
  input  wire vna_vec_t   pos_q,
  output vna_cross_t      xprod
);

  vna_vec_t pa_r;
  vna_vec_t pb_r;
  logic signed [PROD_W-1:0] p_r [6];
  vna_cross_t cross_r;

  logic signed [EDGE_W-1:0] ux, uy, uz, vx, vy, vz;

  // pos_q holds corner c during the multiply step
  assign ux = EDGE_W'(pa_r.x) - EDGE_W'(pb_r.x);
  assign uy = EDGE_W'(pa_r.y) - EDGE_W'(pb_r.y);
  assign uz = EDGE_W'(pa_r.z) - EDGE_W'(pb_r.z);
  assign vx = EDGE_W'(pos_q.x) - EDGE_W'(pb_r.x);
  assign vy = EDGE_W'(pos_q.y) - EDGE_W'(pb_r.y);
  assign vz = EDGE_W'(pos_q.z) - EDGE_W'(pb_r.z);

  always_ff @(posedge clk) begin
    if (ctl.load_pa) begin
      pa_r <= pos_q;
    end
    if (ctl.load_pb) begin
      pb_r <= pos_q;
    end
    if (ctl.mul_en) begin
      p_r[0] <= PROD_W'(uy) * PROD_W'(vz);
      p_r[1] <= PROD_W'(uz) * PROD_W'(vy);
      p_r[2] <= PROD_W'(uz) * PROD_W'(vx);
      p_r[3] <= PROD_W'(ux) * PROD_W'(vz);
      p_r[4] <= PROD_W'(ux) * PROD_W'(vy);
      p_r[5] <= PROD_W'(uy) * PROD_W'(vx);
    end
    if (ctl.cross_en) begin
      cross_r.x <= CROSS_W'(p_r[0]) - CROSS_W'(p_r[1]);
      cross_r.y <= CROSS_W'(p_r[2]) - CROSS_W'(p_r[3]);
      cross_r.z <= CROSS_W'(p_r[4]) - CROSS_W'(p_r[5]);
    end
  end

  assign xprod = cross_r;

endmodule

`default_nettype wire

// ----- src/vna_accum.sv -----
// Saturating normal update with forwarding of the previous corner's write.
// Depends on vna_pkg.
`default_nettype none

module vna_accum
  import vna_pkg::*;
(
  input  wire logic       clk,
  input  wire vna_actl_t  ctl,
  input  wire vna_norm_t  rdata,
  input  wire vna_cross_t xprod,
  output vna_norm_t       wdata
);

  vna_norm_t last_r;
  vna_norm_t base;

  // a repeated corner was read before the previous write landed
  assign base = ctl.fwd ? last_r : rdata;

  always_comb begin
    wdata.x = sat_sub(base.x, xprod.x);
    wdata.y = sat_sub(base.y, xprod.y);
    wdata.z = sat_sub(base.z, xprod.z);
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      last_r <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- src/vna_ctrl.sv -----
// Sequencer: transaction register, clearing pass, memory addressing and result register.
// Depends on vna_pkg.
`default_nettype none

module vna_ctrl
  import vna_pkg::*;
#(
  parameter int VERTEX_DEPTH = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire vna_in_t                         in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output vna_out_t                             out_data,
  output logic                                 pos_we,
  output logic [$clog2(VERTEX_DEPTH)-1:0]      pos_waddr,
  output vna_vec_t                             pos_wdata,
  output logic [$clog2(VERTEX_DEPTH)-1:0]      pos_raddr,
  output logic                                 norm_we,
  output logic [$clog2(VERTEX_DEPTH)-1:0]      norm_waddr,
  output vna_norm_t                            norm_wdata,
  output logic [$clog2(VERTEX_DEPTH)-1:0]      norm_raddr,
  input  wire vna_norm_t                       norm_rdata,
  input  wire vna_norm_t                       acc_wdata,
  output vna_xctl_t                            xctl,
  output vna_actl_t                            actl
);

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_DEPTH - 1);

  vna_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  vna_in_t       item_r;
  logic          rd_ok_r;
  logic          out_valid_r, out_valid_nxt;
  vna_out_t      out_data_r;

  logic          accept;
  logic          out_load;
  logic          idx_ok_in;
  logic          face_ok_in;
  logic [AW-1:0] addr_a, addr_b, addr_c, addr_idx;

  assign accept     = in_valid && in_ready;
  assign idx_ok_in  = 32'(in_data.vertex_index) < VERTEX_DEPTH;
  assign face_ok_in = (32'(in_data.corner_a) < VERTEX_DEPTH)
                   && (32'(in_data.corner_b) < VERTEX_DEPTH)
                   && (32'(in_data.corner_c) < VERTEX_DEPTH);

  assign addr_a   = AW'(item_r.corner_a);
  assign addr_b   = AW'(item_r.corner_b);
  assign addr_c   = AW'(item_r.corner_c);
  assign addr_idx = AW'(item_r.vertex_index);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_FACE: state_nxt = face_ok_in ? ST_RD_A : ST_IDLE;
            OP_READ: state_nxt = ST_RD_N;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_A:  state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = ST_RD_C;
      ST_RD_C:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CROSS;
      ST_CROSS: state_nxt = ST_ACC_A;
      ST_ACC_A: state_nxt = ST_ACC_B;
      ST_ACC_B: state_nxt = ST_ACC_C;
      ST_ACC_C: state_nxt = ST_IDLE;
      ST_RD_N:  state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    pos_we     = 1'b0;
    pos_waddr  = AW'(in_data.vertex_index);
    pos_wdata  = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
    pos_raddr  = addr_a;
    norm_we    = 1'b0;
    norm_waddr = addr_a;
    norm_wdata = acc_wdata;
    norm_raddr = addr_idx;
    xctl       = '0;
    actl       = '0;
    out_load   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        norm_we    = 1'b1;
        norm_waddr = clr_cnt_r;
        norm_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        pos_we   = in_valid && (in_data.op == OP_WRITE) && idx_ok_in;
      end
      ST_RD_A: pos_raddr = addr_a;
      ST_RD_B: begin
        pos_raddr    = addr_b;
        xctl.load_pa = 1'b1;
      end
      ST_RD_C: begin
        pos_raddr    = addr_c;
        xctl.load_pb = 1'b1;
      end
      ST_MUL:  xctl.mul_en = 1'b1;
      ST_CROSS: begin
        xctl.cross_en = 1'b1;
        norm_raddr    = addr_a;
      end
      ST_ACC_A: begin
        norm_raddr = addr_b;
        norm_we    = 1'b1;
        norm_waddr = addr_a;
        actl.we    = 1'b1;
      end
      ST_ACC_B: begin
        norm_raddr = addr_c;
        norm_we    = 1'b1;
        norm_waddr = addr_b;
        actl.we    = 1'b1;
        actl.fwd   = (addr_b == addr_a);
      end
      ST_ACC_C: begin
        norm_we    = 1'b1;
        norm_waddr = addr_c;
        actl.we    = 1'b1;
        actl.fwd   = (addr_c == addr_b);
      end
      ST_RD_N: norm_raddr = addr_idx;
      ST_RESP: begin
        norm_raddr = addr_idx;
        out_load   = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    clr_cnt_nxt = (state_r == ST_CLEAR) ? clr_cnt_r + 1'b1 : clr_cnt_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_data;
      rd_ok_r <= idx_ok_in;
    end
    if (out_load) begin
      out_data_r <= rd_ok_r ? vna_out_t'(norm_rdata) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- src/vertex_normal_accumulator_unit.sv -----
// Vertex normal accumulator. Takes one transaction at a time. A position write goes
// straight from the input to the position memory, a normal read waits out any output
// stall, and a face runs three position reads, a multiply and a cross step, then three
// read-modify-writes of the normal memory that share its single read port and its
// single write port. After reset a clearing pass zeroes the normal memory, during
// which in_ready stays low. Normals are unnormalized, flipped, and saturate at 48 bits.
// Depends on vna_pkg, vna_ram, vna_cross, vna_accum, vna_ctrl.
`default_nettype none

module vertex_normal_accumulator_unit
  import vna_pkg::*;
#(
  parameter int VERTEX_DEPTH = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire vna_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output vna_out_t      out_data
);

  localparam int AW = $clog2(VERTEX_DEPTH);

  logic          pos_we;
  logic [AW-1:0] pos_waddr, pos_raddr;
  vna_vec_t      pos_wdata, pos_rdata;
  logic          norm_we;
  logic [AW-1:0] norm_waddr, norm_raddr;
  vna_norm_t     norm_wdata, norm_rdata, acc_wdata;
  vna_cross_t    xprod;
  vna_xctl_t     xctl;
  vna_actl_t     actl;

  vna_ctrl #(
    .VERTEX_DEPTH(VERTEX_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .pos_we     (pos_we),
    .pos_waddr  (pos_waddr),
    .pos_wdata  (pos_wdata),
    .pos_raddr  (pos_raddr),
    .norm_we    (norm_we),
    .norm_waddr (norm_waddr),
    .norm_wdata (norm_wdata),
    .norm_raddr (norm_raddr),
    .norm_rdata (norm_rdata),
    .acc_wdata  (acc_wdata),
    .xctl       (xctl),
    .actl       (actl)
  );

  vna_ram #(
    .WIDTH($bits(vna_vec_t)),
    .DEPTH(VERTEX_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vna_ram #(
    .WIDTH($bits(vna_norm_t)),
    .DEPTH(VERTEX_DEPTH)
  ) u_norm_ram (
    .clk   (clk),
    .we    (norm_we),
    .waddr (norm_waddr),
    .wdata (norm_wdata),
    .raddr (norm_raddr),
    .rdata (norm_rdata)
  );

  vna_cross u_cross (
    .clk   (clk),
    .ctl   (xctl),
    .pos_q (pos_rdata),
    .xprod (xprod)
  );

  vna_accum u_accum (
    .clk   (clk),
    .ctl   (actl),
    .rdata (norm_rdata),
    .xprod (xprod),
    .wdata (acc_wdata)
  );

endmodule

`default_nettype wire

// ----- src/vna_checker.sv -----
// Port-level checks for the vertex normal accumulator, bound into the top level.
// Depends on vna_pkg and vertex_normal_accumulator_unit.
`default_nettype none

module vna_checker
  import vna_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire vna_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire vna_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // reset starts the clearing pass, so no transaction is taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // only a read produces a result
  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op != OP_READ) && !out_valid |=> !out_valid)
    else $error("result without a read");

  // a read occupies the block for at least the memory access
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_READ) |=> !in_ready)
    else $error("input ready while a read is in flight");

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (.*);

`default_nettype wire

// ----- bench/tb_vertex_normal_accumulator_unit.sv -----
// Self-checking bench for vertex_normal_accumulator_unit: position writes, face
// accumulation and normal reads checked against a predictor kept in this file.
// Depends on vna_pkg and the vertex_normal_accumulator_unit RTL.
module tb_vertex_normal_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  localparam int VERTEX_COUNT     = 4096;
  localparam int RANDOM_PER_PHASE = 480;
  // a repeated extreme face; the 48-bit limits would need about 2^15 of these
  localparam int SAT_FACES        = 16;
  localparam int SAT_A            = 4093;
  localparam int SAT_B            = 4094;
  localparam int SAT_C            = 4095;
  localparam int DRAIN_CYCLES     = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
  localparam longint NORM_HI = (longint'(1) <<< (NORMAL_W - 1)) - 1;
  localparam longint NORM_LO = -NORM_HI - 1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  vna_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vna_out_t out_data;

  vna_in_t   pending_items[$];
  vna_out_t  normal_reads_due[$];
  vna_out_t  oldest_due;
  vna_vec_t  vertex_pos[VERTEX_COUNT];
  vna_norm_t vertex_norm[VERTEX_COUNT];
  bit        vertex_set[VERTEX_COUNT];
  int        set_list[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned writes_seen = 0;
  int unsigned faces_seen = 0;
  int unsigned reads_seen = 0;
  int unsigned unused_seen = 0;
  int unsigned reads_checked = 0;
  bit          hit_norm_lo = 1'b0;
  bit          hit_norm_hi = 1'b0;

  vertex_normal_accumulator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [NORMAL_W-1:0] clamp_minus(
    logic signed [NORMAL_W-1:0] acc,
    longint d
  );
    longint diff;
    diff = longint'(acc) - d;
    if (diff > NORM_HI) diff = NORM_HI;
    else if (diff < NORM_LO) diff = NORM_LO;
    return diff[NORMAL_W-1:0];
  endfunction

  function automatic vna_norm_t pull_normal(vna_norm_t n, longint cx, longint cy,
                                            longint cz);
    vna_norm_t r;
    r.x = clamp_minus(n.x, cx);
    r.y = clamp_minus(n.y, cy);
    r.z = clamp_minus(n.z, cz);
    return r;
  endfunction

  task automatic track_transaction(input vna_in_t t);
    vna_vec_t pa, pb, pc;
    longint   ux, uy, uz, vx, vy, vz;
    longint   cx, cy, cz;
    vna_out_t due;
    case (t.op)
      OP_WRITE: begin
        vertex_pos[t.vertex_index] = {t.pos_x, t.pos_y, t.pos_z};
        writes_seen++;
      end
      OP_FACE: begin
        pa = vertex_pos[t.corner_a];
        pb = vertex_pos[t.corner_b];
        pc = vertex_pos[t.corner_c];
        ux = longint'($signed(pa.x)) - longint'($signed(pb.x));
        uy = longint'($signed(pa.y)) - longint'($signed(pb.y));
        uz = longint'($signed(pa.z)) - longint'($signed(pb.z));
        vx = longint'($signed(pc.x)) - longint'($signed(pb.x));
        vy = longint'($signed(pc.y)) - longint'($signed(pb.y));
        vz = longint'($signed(pc.z)) - longint'($signed(pb.z));
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        // corners updated one after another, so a repeated corner is hit twice
        vertex_norm[t.corner_a] = pull_normal(vertex_norm[t.corner_a], cx, cy, cz);
        vertex_norm[t.corner_b] = pull_normal(vertex_norm[t.corner_b], cx, cy, cz);
        vertex_norm[t.corner_c] = pull_normal(vertex_norm[t.corner_c], cx, cy, cz);
        faces_seen++;
      end
      OP_READ: begin
        due.normal_x = vertex_norm[t.vertex_index].x;
        due.normal_y = vertex_norm[t.vertex_index].y;
        due.normal_z = vertex_norm[t.vertex_index].z;
        normal_reads_due.push_back(due);
        reads_seen++;
      end
      default: unused_seen++;
    endcase
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) track_transaction(in_data);
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic compare_component(input string name,
                                   input logic signed [NORMAL_W-1:0] expected,
                                   input logic signed [NORMAL_W-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: normal_%s mismatch, expected %0d, actual %0d",
               $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (normal_reads_due.size() == 0) begin
          $display("%0t: result with no read pending, expected none, actual %0d %0d %0d",
                   $time, out_data.normal_x, out_data.normal_y, out_data.normal_z);
          mismatch_count++;
        end else begin
          oldest_due = normal_reads_due.pop_front();
          compare_component("x", oldest_due.normal_x, out_data.normal_x);
          compare_component("y", oldest_due.normal_y, out_data.normal_y);
          compare_component("z", oldest_due.normal_z, out_data.normal_z);
          if (oldest_due.normal_x == NORM_LO || oldest_due.normal_z == NORM_LO)
            hit_norm_lo = 1'b1;
          if (oldest_due.normal_x == NORM_HI || oldest_due.normal_z == NORM_HI)
            hit_norm_hi = 1'b1;
          reads_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic vna_in_t noise_item();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(vna_in_t)-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // mostly a small pool so vertices get reused, sometimes anywhere
  function automatic int pick_vertex();
    if ($urandom_range(3) != 0) return $urandom_range(63);
    return $urandom_range(VERTEX_COUNT - 1);
  endfunction

  function automatic int pick_written();
    return set_list[$urandom_range(set_list.size() - 1)];
  endfunction

  task automatic queue_write(input int idx, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    vna_in_t t;
    t = noise_item();
    t.op = OP_WRITE;
    t.vertex_index = INDEX_W'(idx);
    t.pos_x = x;
    t.pos_y = y;
    t.pos_z = z;
    pending_items.push_back(t);
    if (!vertex_set[idx]) begin
      vertex_set[idx] = 1'b1;
      set_list.push_back(idx);
    end
  endtask

  task automatic queue_face(input int a, input int b, input int c);
    vna_in_t t;
    t = noise_item();
    t.op = OP_FACE;
    t.corner_a = INDEX_W'(a);
    t.corner_b = INDEX_W'(b);
    t.corner_c = INDEX_W'(c);
    pending_items.push_back(t);
  endtask

  task automatic queue_read(input int idx);
    vna_in_t t;
    t = noise_item();
    t.op = OP_READ;
    t.vertex_index = INDEX_W'(idx);
    pending_items.push_back(t);
  endtask

  task automatic queue_unused();
    vna_in_t t;
    t = noise_item();
    t.op = OP_UNUSED;
    pending_items.push_back(t);
  endtask

  task automatic queue_random(input int count);
    int n;
    int roll;
    int a;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        queue_unused();
        continue;
      end
      if (roll < 35) begin
        queue_write(pick_vertex(), pick_coord(), pick_coord(), pick_coord());
      end else if (roll < 72) begin
        a = pick_written();
        if ($urandom_range(9) == 0) queue_face(a, pick_written(), a);
        else queue_face(a, pick_written(), pick_written());
      end else begin
        queue_read(($urandom_range(1) != 0) ? pick_written() : pick_vertex());
      end
      n++;
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || normal_reads_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int i;
    for (i = 0; i < VERTEX_COUNT; i++) begin
      vertex_pos[i] = '0;
      vertex_norm[i] = '0;
      vertex_set[i] = 1'b0;
    end
    send_idle_pct = 33;
    recv_idle_pct = 64;

    // cleared normals, extremes of index and coordinates, degenerate faces
    queue_read(0);
    queue_read(VERTEX_COUNT - 1);
    queue_write(0, COORD_MAX, COORD_MAX, COORD_MAX);
    queue_write(VERTEX_COUNT - 1, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_write(1, '0, '0, '0);
    queue_write(2, -16'sd1, 16'sd256, -16'sd256);
    queue_write(2730, 16'sd12345, -16'sd23456, COORD_MAX);
    queue_face(0, VERTEX_COUNT - 1, 1);
    queue_face(VERTEX_COUNT - 1, 2, 0);
    queue_face(2730, 1, 2);
    queue_face(0, 0, 1);
    queue_face(1, 1, 1);
    queue_face(2, 2730, 2);
    queue_unused();
    queue_read(0);
    queue_read(VERTEX_COUNT - 1);
    queue_read(1);
    queue_read(2);
    queue_read(2730);
    queue_read(1365);
    queue_write(0, COORD_MIN, COORD_MAX, '0);
    queue_face(0, 1, 2);
    queue_read(0);
    queue_random(RANDOM_PER_PHASE);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct = 33;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    // x runs negative and z positive on all three corners
    queue_write(SAT_A, COORD_MIN, COORD_MAX, COORD_MIN);
    queue_write(SAT_B, COORD_MIN, COORD_MIN, '0);
    queue_write(SAT_C, COORD_MAX, COORD_MAX, COORD_MAX);
    for (i = 0; i < SAT_FACES; i++) queue_face(SAT_A, SAT_B, SAT_C);
    queue_read(SAT_A);
    queue_read(SAT_B);
    queue_read(SAT_C);
    // reversed winding takes one face back off
    queue_face(SAT_C, SAT_B, SAT_A);
    queue_read(SAT_A);
    queue_read(SAT_B);
    queue_read(SAT_C);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: %0d position writes, %0d faces, %0d reads (%0d results checked)",
             writes_seen, faces_seen, reads_seen, reads_checked);
    $display("summary: %0d unused-op transactions, low limit %0s, high limit %0s",
             unused_seen, hit_norm_lo ? "reached" : "missed",
             hit_norm_hi ? "reached" : "missed");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d transactions still queued", pending_items.size());
    $display("tb: failure");
    $finish;
  end

endmodule
